FILE: rtl/accel_step_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer step detector
// Concurrent assertion wrappers that use the clk_i and rst_ni names of each
// asserting module. Defining ASSERT_OFF turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef ACCEL_STEP_DETECTOR_DEFINES_SVH
`define ACCEL_STEP_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked while reset is released.
`define ASD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define ASD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASD_ASSERT(lbl, prop, msg)
`define ASD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/asd_pkg.sv
// ----------------------------------------------------------------------------
// Step detector package
// Shared constants, register indexes and the types passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

  localparam int unsigned NUM_AXES     = 3;
  localparam int unsigned WINDOW_DEPTH = 4;
  localparam int unsigned WIN_SHIFT    = $clog2(WINDOW_DEPTH);
  localparam int unsigned SLOT_W       = WIN_SHIFT;
  localparam int unsigned FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PREC_W       = 12;
  localparam int unsigned PERIOD_W     = 8;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 12;

  localparam logic [PREC_W-1:0]   PREC_RESET   = 12'd150;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd50;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANGE_PRECISION = 2'd0,
    REG_THRESHOLD_PERIOD = 2'd1
  } cfg_reg_e;

  // Window fill status before and after the current item.
  typedef struct packed {
    logic full_pre;
    logic full_post;
  } fill_t;

  // Step result after the current item.
  typedef struct packed {
    logic               step;
    logic [TOTAL_W-1:0] total;
    axis_e              axis;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/accel_step_detector.sv
// ----------------------------------------------------------------------------
// Three-axis accelerometer step detector
// Moving averages, dynamic thresholds and step counting for a pedometer.
// ----------------------------------------------------------------------------
// One item on the input channel is one sample of the three axes plus the
// holdoff-expired flag from the external timer. Every input item produces
// exactly one result item: the step flag, the running step total, the axis
// of the last step and the three moving averages with their valid flag.
// An item is held in an input register, then add, compare and select logic
// updates the detector state and loads the result register.
// A result item is valid once the result register has loaded it, and one
// item is accepted in every cycle while the receiver keeps taking results.
// When the receiver stalls, the result register holds its item and the
// input register still takes one more item; after that in_ready_o drops
// until the result moves on.
// The configuration channel is always ready; writes are registered and
// are meant to happen while no item is in flight. Unknown indexes are
// ignored. Reset clears the window, thresholds, extrema, counters and the
// holdoff, and loads the register defaults (precision 150, period 50).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "accel_step_detector_defines.svh"

module accel_step_detector #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write channel.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [asd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [asd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Sample channel.
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]           accel_x_i,
  input  wire logic [SAMPLE_BITS-1:0]           accel_y_i,
  input  wire logic [SAMPLE_BITS-1:0]           accel_z_i,
  input  wire logic                             holdoff_expired_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  step_detected_o,
  output logic [asd_pkg::TOTAL_W-1:0]           total_steps_o,
  output logic [1:0]                            step_axis_o,
  output logic [SAMPLE_BITS-1:0]                mean_x_o,
  output logic [SAMPLE_BITS-1:0]                mean_y_o,
  output logic [SAMPLE_BITS-1:0]                mean_z_o,
  output logic                                  mean_valid_o
);
  import asd_pkg::*;

  // Configuration registers.
  logic [PREC_W-1:0]   prec_q;
  logic [PERIOD_W-1:0] period_q;

  // Input register stage.
  logic                                 in_valid_q;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] sample_q;
  logic                                 expired_q;

  // Result register stage.
  logic                                 out_valid_q;
  logic                                 out_step_q;
  logic [TOTAL_W-1:0]                   out_total_q;
  axis_e                                out_axis_q;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] out_mean_q;
  logic                                 out_mvalid_q;

  logic                                 fire;
  logic                                 in_accept;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] mean;
  fill_t                                fill;
  result_t                              result;

  // The held item moves into the result register whenever that register is
  // empty or being emptied in this cycle; that move is also the state update.
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q   <= PREC_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CHANGE_PRECISION: prec_q   <= cfg_data_i[PREC_W-1:0];
        REG_THRESHOLD_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q[0] <= accel_x_i;
      sample_q[1] <= accel_y_i;
      sample_q[2] <= accel_z_i;
      expired_q   <= holdoff_expired_i;
    end
  end

  asd_window #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .sample_i(sample_q),
    .mean_o  (mean),
    .fill_o  (fill)
  );

  asd_detect #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_detect (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .holdoff_expired_i(expired_q),
    .full_i           (fill.full_pre),
    .mean_i           (mean),
    .prec_i           (prec_q),
    .period_i         (period_q),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Means read as zero until the window has been filled once.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_step_q   <= result.step;
      out_total_q  <= result.total;
      out_axis_q   <= result.axis;
      out_mvalid_q <= fill.full_post;
      for (int i = 0; i < NUM_AXES; i++) begin
        out_mean_q[i] <= fill.full_post ? mean[i] : '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_detected_o = out_step_q;
  assign total_steps_o   = out_total_q;
  assign step_axis_o     = out_axis_q;
  assign mean_x_o        = out_mean_q[0];
  assign mean_y_o        = out_mean_q[1];
  assign mean_z_o        = out_mean_q[2];
  assign mean_valid_o    = out_mvalid_q;

  `ASD_ASSERT(a_step_needs_window, out_valid_o && step_detected_o |-> mean_valid_o, "step before window full")
  `ASD_ASSERT(a_no_overwrite, out_valid_q && !out_ready_i |-> !fire, "result overwritten while stalled")
  `ASD_ASSERT(a_held_item_kept, in_valid_q && !fire |=> in_valid_q, "held item dropped")

endmodule

`default_nettype wire

FILE: rtl/asd_window.sv
// ----------------------------------------------------------------------------
// Moving average window
// Keeps the last samples of each axis, pre-divided, and the running means.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "accel_step_detector_defines.svh"

module asd_window #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        fire_i,
  input  wire logic [asd_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] sample_i,
  output logic      [asd_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] mean_o,
  output asd_pkg::fill_t                                   fill_o
);
  import asd_pkg::*;

  localparam int unsigned QW = SAMPLE_BITS - WIN_SHIFT;

  // Samples are stored already divided by the window depth.
  logic [NUM_AXES-1:0][WINDOW_DEPTH-1:0][QW-1:0] win_q;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]          mean_q, mean_d;
  logic [SLOT_W-1:0]                             slot_q, slot_d;
  logic [FILL_W-1:0]                             fill_q;
  logic                                          full_pre;

  assign full_pre         = (fill_q >= FILL_W'(WINDOW_DEPTH));
  assign fill_o.full_pre  = full_pre;
  assign fill_o.full_post = full_pre || (fill_q == FILL_W'(WINDOW_DEPTH - 1));
  assign slot_d = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mean_d[i] = mean_q[i] + {{WIN_SHIFT{1'b0}}, sample_i[i][SAMPLE_BITS-1:WIN_SHIFT]};
      if (full_pre) begin
        mean_d[i] = mean_d[i] - {{WIN_SHIFT{1'b0}}, win_q[i][slot_q]};
      end
    end
  end

  assign mean_o = mean_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      slot_q <= '0;
      fill_q <= '0;
    end else if (fire_i) begin
      mean_q <= mean_d;
      slot_q <= slot_d;
      if (!full_pre) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Every slot is written before it is ever subtracted, so no reset is needed.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        win_q[i][slot_q] <= sample_i[i][SAMPLE_BITS-1:WIN_SHIFT];
      end
    end
  end

  `ASD_ASSERT(a_fill_bounded, fill_q <= FILL_W'(WINDOW_DEPTH), "fill count overran depth")

endmodule

`default_nettype wire

FILE: rtl/asd_detect.sv
// ----------------------------------------------------------------------------
// Step decision logic
// Extrema, dynamic thresholds, change-gated shift stages, dominant axis and
// the step counter with its holdoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "accel_step_detector_defines.svh"

module asd_detect #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          fire_i,
  input  wire logic                                          holdoff_expired_i,
  input  wire logic                                          full_i,
  input  wire logic [asd_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] mean_i,
  input  wire logic [asd_pkg::PREC_W-1:0]                    prec_i,
  input  wire logic [asd_pkg::PERIOD_W-1:0]                  period_i,
  output asd_pkg::result_t                                   result_o
);
  import asd_pkg::*;

  localparam int unsigned CW = (SAMPLE_BITS > PREC_W) ? SAMPLE_BITS : PREC_W;
  localparam logic [SAMPLE_BITS:0] MinReset = (SAMPLE_BITS + 1)'((1 << SAMPLE_BITS) + 1);

  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] thr_q, thr_d;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] max_q, max_d;
  logic [NUM_AXES-1:0][SAMPLE_BITS:0]   min_q, min_d;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] newer_q, newer_d;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] older_q, older_d;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] move, spread;
  logic [NUM_AXES-1:0][SAMPLE_BITS+1:0] mid_sum;
  logic [PERIOD_W-1:0]                  phase_q, phase_d;
  logic                                 wrap;
  logic [TOTAL_W-1:0]                   total_q;
  axis_e                                axis_q;
  logic                                 holdoff_q, holdoff_pre;
  logic [1:0]                           dom_idx;
  axis_e                                dom_axis;
  logic                                 step;
  result_t                              res;

  always_comb begin
    phase_d = phase_q + 1'b1;
    if ((period_i != '0) && (phase_d >= period_i)) begin
      phase_d = '0;
    end
    wrap = (phase_d == '0);
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mid_sum[i] = {2'b00, max_q[i]} + {1'b0, min_q[i]};
      thr_d[i]   = wrap ? mid_sum[i][SAMPLE_BITS:1] : thr_q[i];
      max_d[i]   = wrap ? '0 : max_q[i];
      min_d[i]   = wrap ? MinReset : min_q[i];
      older_d[i] = older_q[i];
      newer_d[i] = newer_q[i];
      move[i]    = (mean_i[i] >= newer_q[i]) ? mean_i[i] - newer_q[i] : newer_q[i] - mean_i[i];
      if (full_i) begin
        if (mean_i[i] > max_d[i]) begin
          max_d[i] = mean_i[i];
        end
        if ({1'b0, mean_i[i]} < min_d[i]) begin
          min_d[i] = {1'b0, mean_i[i]};
        end
        older_d[i] = newer_q[i];
        if (CW'(move[i]) > CW'(prec_i)) begin
          newer_d[i] = mean_i[i];
        end
      end
      spread[i] = (older_d[i] >= newer_d[i]) ? older_d[i] - newer_d[i]
                                             : newer_d[i] - older_d[i];
    end
  end

  // Ties go to x, then y.
  always_comb begin
    priority if ((spread[0] >= spread[1]) && (spread[0] >= spread[2])) begin
      dom_idx  = 2'd0;
      dom_axis = AXIS_X;
    end else if ((spread[1] >= spread[0]) && (spread[1] >= spread[2])) begin
      dom_idx  = 2'd1;
      dom_axis = AXIS_Y;
    end else begin
      dom_idx  = 2'd2;
      dom_axis = AXIS_Z;
    end
  end

  assign holdoff_pre = holdoff_q && !holdoff_expired_i;
  assign step = full_i && !holdoff_pre
             && (older_d[dom_idx] > thr_d[dom_idx])
             && (newer_d[dom_idx] < thr_d[dom_idx]);

  assign res.step  = step;
  assign res.total = total_q + TOTAL_W'(step);
  assign res.axis  = step ? dom_axis : axis_q;
  assign result_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      max_q     <= '0;
      min_q     <= {NUM_AXES{MinReset}};
      newer_q   <= '0;
      older_q   <= '0;
      phase_q   <= '0;
      total_q   <= '0;
      axis_q    <= AXIS_NONE;
      holdoff_q <= 1'b0;
    end else if (fire_i) begin
      thr_q     <= thr_d;
      max_q     <= max_d;
      min_q     <= min_d;
      newer_q   <= newer_d;
      older_q   <= older_d;
      phase_q   <= phase_d;
      total_q   <= res.total;
      axis_q    <= res.axis;
      holdoff_q <= step || holdoff_pre;
    end
  end

  `ASD_ASSERT(a_step_counts, fire_i && step |=> total_q == $past(total_q) + 32'd1, "step count did not advance")
  `ASD_ASSERT(a_step_holds_off, fire_i && step |=> holdoff_q, "holdoff not armed after step")

endmodule

`default_nettype wire
